@@ src/utf8_to_utf16_transcoder_top_macros.svh @@
// Assertion macros used by the transcoder top level.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define U8U16_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define U8U16_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define U8U16_ASSERT(lbl, prop)
`define U8U16_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ src/u8u16_pkg.sv @@
// Types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccW   = 21;
  localparam int unsigned PendW  = 2;
  localparam int unsigned NResW  = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned OutDataW  = 24;

  localparam logic [UnitW-1:0] UnitQuestion = 16'h003F;
  localparam logic [UnitW-1:0] SurrHiBase   = 16'hD800;
  localparam logic [UnitW-1:0] SurrLoBase   = 16'hDC00;
  localparam logic [AccW-1:0]  CpMax        = 21'h10FFFF;
  localparam logic [AccW-1:0]  CpBmpMax     = 21'h00FFFF;

  // One result item.
  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             is_status;
    logic             ok;
    logic             last_of_run;
  } result_t;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [PendW-1:0] pending_count;
    logic [AccW-1:0]  accumulator;
    logic             skipping;
  } dec_state_t;

endpackage

@@ src/u8u16_decode.sv @@
// Single-byte decode step: next state and up to two result items.
module u8u16_decode (
  input  logic [u8u16_pkg::ByteW-1:0] byte_i,
  input  u8u16_pkg::dec_state_t       state_i,
  output u8u16_pkg::dec_state_t       state_o,
  output logic [u8u16_pkg::NResW-1:0] n_res_o,
  output u8u16_pkg::result_t          res0_o,
  output u8u16_pkg::result_t          res1_o
);

  logic [u8u16_pkg::AccW-1:0] acc_shift;
  logic [u8u16_pkg::AccW-1:0] cp_off;
  logic                       is_cont;

  assign acc_shift = {state_i.accumulator[u8u16_pkg::AccW-7:0], byte_i[5:0]};
  assign cp_off    = acc_shift - 21'h010000;
  assign is_cont   = (byte_i[7:6] == 2'b10);

  always_comb begin
    state_o = state_i;
    n_res_o = 2'd0;
    res0_o  = '0;
    res1_o  = '0;
    res0_o.last_of_run = 1'b1;
    res1_o.last_of_run = 1'b1;
    priority if (state_i.skipping) begin
      // drop everything up to the terminator
      if (byte_i == 8'h00) state_o.skipping = 1'b0;
    end else if (state_i.pending_count != 2'd0) begin
      if (!is_cont) begin
        state_o.pending_count = 2'd0;
        state_o.accumulator   = '0;
        state_o.skipping      = (byte_i != 8'h00);
        n_res_o               = 2'd1;
        res0_o.is_status      = 1'b1;
      end else if (state_i.pending_count != 2'd1) begin
        state_o.pending_count = state_i.pending_count - 2'd1;
        state_o.accumulator   = acc_shift;
      end else begin
        state_o.pending_count = 2'd0;
        state_o.accumulator   = '0;
        n_res_o               = 2'd1;
        priority if (acc_shift == '0 || acc_shift > u8u16_pkg::CpMax) begin
          state_o.skipping = 1'b1;
          res0_o.is_status = 1'b1;
        end else if (acc_shift <= u8u16_pkg::CpBmpMax) begin
          res0_o.unit = acc_shift[u8u16_pkg::UnitW-1:0];
        end else begin
          n_res_o            = 2'd2;
          res0_o.unit        = u8u16_pkg::SurrHiBase | {6'd0, cp_off[19:10]};
          res0_o.last_of_run = 1'b0;
          res1_o.unit        = u8u16_pkg::SurrLoBase | {6'd0, cp_off[9:0]};
        end
      end
    end else if (byte_i == 8'h00) begin
      n_res_o          = 2'd1;
      res0_o.is_status = 1'b1;
      res0_o.ok        = 1'b1;
    end else if (byte_i[7] == 1'b0) begin
      n_res_o     = 2'd1;
      res0_o.unit = {8'd0, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      state_o.accumulator   = {16'd0, byte_i[4:0]};
      state_o.pending_count = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      state_o.accumulator   = {17'd0, byte_i[3:0]};
      state_o.pending_count = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      state_o.accumulator   = {18'd0, byte_i[2:0]};
      state_o.pending_count = 2'd3;
    end else begin
      n_res_o     = 2'd1;
      res0_o.unit = u8u16_pkg::UnitQuestion;
    end
  end

endmodule

@@ src/utf8_to_utf16_transcoder_top.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: input register, decode, output queue.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] byte_in
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata[15:0] unit, [16] ok; tuser is_status;
//                                                tlast last_of_run
//
// One byte is taken per cycle while s_axis_tready is high. A byte waits in the input
// register, is decoded and pushes zero, one or two results into a four-entry output queue
// whose head drives m_axis: m_axis_tvalid is high while the registered queue count is
// non-zero. A surrogate pair takes two queue slots;
// hold the input register and drop s_axis_tready whenever fewer than
// two queue slots are free. Reset clears decoder state, input valid flag and queue.
`include "utf8_to_utf16_transcoder_top_macros.svh"

module utf8_to_utf16_transcoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] unit, [16] ok, [23:17] zero
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast    // last_of_run
);

  // input register
  logic                          in_vld_q;
  logic [u8u16_pkg::ByteW-1:0]   in_byte_q;
  logic                          in_accept;
  logic                          advance;

  // decoder state
  u8u16_pkg::dec_state_t         st_q, st_d;
  logic [u8u16_pkg::NResW-1:0]   n_res;
  u8u16_pkg::result_t            res0, res1;

  // output queue
  u8u16_pkg::result_t            fifo_q [u8u16_pkg::FifoDepth];
  logic [u8u16_pkg::FifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [u8u16_pkg::FifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [u8u16_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic                          pop;
  logic [u8u16_pkg::FifoAw-1:0]  wr_ptr_p1;
  u8u16_pkg::result_t            head;

  // Advance the held byte only when two queue slots are surely free.
  assign advance       = in_vld_q && (cnt_q <= u8u16_pkg::FifoCntW'(u8u16_pkg::FifoDepth - 2));
  assign s_axis_tready = !in_vld_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  u8u16_decode u_decode (
    .byte_i  (in_byte_q),
    .state_i (st_q),
    .state_o (st_d),
    .n_res_o (n_res),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Queue bookkeeping: push the decoded results, pop on an output transaction.
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_p1 = wr_ptr_q + u8u16_pkg::FifoAw'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (advance) begin
      wr_ptr_d = wr_ptr_q + u8u16_pkg::FifoAw'(n_res);
      cnt_d    = cnt_q + u8u16_pkg::FifoCntW'(n_res);
    end
    if (pop) begin
      cnt_d = cnt_d - u8u16_pkg::FifoCntW'(1);
    end
    rd_ptr_d = pop ? rd_ptr_q + u8u16_pkg::FifoAw'(1) : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (advance && n_res == 2'd2) begin
      fifo_q[wr_ptr_p1] <= res1;
    end
  end

  // Drive the stream from the queue head.
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {7'd0, head.ok, head.unit};
  assign m_axis_tuser  = head.is_status;
  assign m_axis_tlast  = head.last_of_run;

  // The queue never holds more than its depth.
  `U8U16_ASSERT_NEVER(a_cnt_bound, cnt_q > u8u16_pkg::FifoCntW'(u8u16_pkg::FifoDepth))
  // Skipping only starts once a sequence is abandoned or ends invalid, never with bytes pending.
  `U8U16_ASSERT_NEVER(a_skip_idle, st_q.skipping && st_q.pending_count != 2'd0)
  // A pair is always a high surrogate followed by a low one.
  `U8U16_ASSERT(a_surr_pair, (advance && n_res == 2'd2) |->
      (res0.unit[15:10] == 6'b110110 && res1.unit[15:10] == 6'b110111 &&
       !res0.last_of_run))

endmodule
